// ----- hw/rtl/process_queue_with_delete_top_assert.svh -----
// Assertion macros for the process queue top level.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef PROCESS_QUEUE_WITH_DELETE_TOP_ASSERT_SVH
`define PROCESS_QUEUE_WITH_DELETE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PQWD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pqwd assertion failed");
// next-cycle implication
`define PQWD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pqwd assertion failed");
`else
`define PQWD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PQWD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hw/rtl/pqwd_pkg.sv -----
// Shared types and codes for the process queue with delete-by-id.
// No dependencies.
package pqwd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int ID_FIELD_W    = 8;
    localparam int COUNT_FIELD_W = 5;

    localparam logic [1:0] CMD_PUSH      = 2'd0;
    localparam logic [1:0] CMD_POP       = 2'd1;
    localparam logic [1:0] CMD_DROP_TAIL = 2'd2;
    localparam logic [1:0] CMD_DELETE_ID = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]            command;
        logic [ID_FIELD_W-1:0] proc_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [COUNT_FIELD_W-1:0] count;
        logic [ID_FIELD_W-1:0]    head_id;
        logic [ID_FIELD_W-1:0]    tail_id;
    } res_t;

endpackage

// ----- hw/rtl/pqwd_engine.sv -----
// Queue storage and command sequencer: ring buffer in a one-write, one-read
// memory, offset adders and one id comparator stepped by a small state machine.
// Depends on pqwd_pkg.
module pqwd_engine #(
    parameter int QUEUE_DEPTH = pqwd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = pqwd_pkg::ID_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  pqwd_pkg::cmd_t  cmd,
    input  logic            res_free,
    output logic            res_load,
    output pqwd_pkg::res_t  res
);
    import pqwd_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_HEAD  = 3'd4;
    localparam logic [2:0] S_TAIL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         state_reg,   state_next;
    logic [IW-1:0]      head_reg,    head_next;
    logic [CW-1:0]      count_reg,   count_next;
    logic [CW-1:0]      off_reg,     off_next;
    logic [1:0]         cmd_reg,     cmd_next;
    logic [ID_BITS-1:0] pid_reg,     pid_next;
    logic [1:0]         status_reg,  status_next;
    logic [ID_BITS-1:0] head_id_reg, head_id_next;

    logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;
    logic [CW-1:0]      rd_off, wr_off;
    logic [IW-1:0]      rd_addr, wr_addr;
    logic               wr_en;
    logic [ID_BITS-1:0] wr_data;
    logic [CW:0]        off_inc, off_inc2;
    logic [ID_BITS-1:0] tail_id;

    // ring index: base + offset, offset below the depth
    function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(QUEUE_DEPTH))
            s = s - (CW+1)'(QUEUE_DEPTH);
        return s[IW-1:0];
    endfunction

    assign rd_addr  = wrap_idx(head_reg, rd_off);
    assign wr_addr  = wrap_idx(head_reg, wr_off);
    assign off_inc  = (CW+1)'(off_reg) + (CW+1)'(1);
    assign off_inc2 = (CW+1)'(off_reg) + (CW+1)'(2);

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        off_next     = off_reg;
        cmd_next     = cmd_reg;
        pid_next     = pid_reg;
        status_next  = status_reg;
        head_id_next = head_id_reg;
        rd_off       = off_reg;
        wr_off       = count_reg;
        wr_en        = 1'b0;
        wr_data      = pid_reg;
        res_load     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd.command;
                    pid_next    = ID_BITS'(cmd.proc_id);
                    status_next = ST_DONE;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_HEAD;
                if (cmd_reg == CMD_PUSH)
                begin
                    if (count_reg == CW'(QUEUE_DEPTH))
                        status_next = ST_FULL;
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_off     = count_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (cmd_reg == CMD_POP)
                begin
                    rd_off     = CW'(1);
                    head_next  = rd_addr;
                    count_next = count_reg - CW'(1);
                end
                else if (cmd_reg == CMD_DROP_TAIL)
                    count_next = count_reg - CW'(1);
                else
                begin
                    rd_off     = '0;
                    off_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rd_data_reg holds the entry at off_reg
                if (rd_data_reg == pid_reg)
                begin
                    if (off_inc < (CW+1)'(count_reg))
                    begin
                        rd_off     = CW'(off_inc);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_HEAD;
                    end
                end
                else if (off_inc < (CW+1)'(count_reg))
                begin
                    rd_off   = CW'(off_inc);
                    off_next = CW'(off_inc);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_HEAD;
                end
            end
            S_SHIFT:
            begin
                // move entry off+1 into the gap at off
                wr_en    = 1'b1;
                wr_off   = off_reg;
                wr_data  = rd_data_reg;
                off_next = CW'(off_inc);
                if (off_inc2 < (CW+1)'(count_reg))
                    rd_off = CW'(off_inc2);
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                rd_off     = '0;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                head_id_next = (count_reg == '0) ? '0 : rd_data_reg;
                rd_off       = (count_reg == '0) ? '0 : count_reg - CW'(1);
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // keep the tail entry on the read port while the result waits
                rd_off = (count_reg == '0) ? '0 : count_reg - CW'(1);
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign tail_id     = (count_reg == '0) ? '0 : rd_data_reg;
    assign res.status  = status_reg;
    assign res.count   = COUNT_FIELD_W'(count_reg);
    assign res.head_id = ID_FIELD_W'(head_id_reg);
    assign res.tail_id = ID_FIELD_W'(tail_id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg     <= off_next;
        cmd_reg     <= cmd_next;
        pid_reg     <= pid_next;
        status_reg  <= status_next;
        head_id_reg <= head_id_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/process_queue_with_delete_top.sv -----
// Top level of the process queue with delete-by-id: sequencer plus result register.
// Depends on pqwd_pkg, pqwd_engine and process_queue_with_delete_top_assert.svh.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one request: push, pop,
//   drop tail, or delete the head-most entry matching proc_id.
//   res channel (res_valid/res_ready/res) returns exactly one result per
//   request: status, count after the request, head and tail ids.
// Timing:
//   One request at a time; cmd_ready is low while a request is in work.
//   Push, pop, drop tail, and any request refused as empty or full: result
//   registered after the EXEC, HEAD, TAIL and DONE states. Delete by id walks
//   the queue through the single memory read port: SCAN compares entries from
//   the head, and on a match SHIFT moves each later entry down one slot before
//   HEAD, TAIL and DONE; a miss scans every entry.
// Reset:
//   Queue empty, no result pending; memory contents are not cleared.
// Stall:
//   A held result does not block acceptance of the next request; that
//   request finishes only once the result register has been taken.
module process_queue_with_delete_top #(
    parameter int QUEUE_DEPTH = pqwd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = pqwd_pkg::ID_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  pqwd_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output pqwd_pkg::res_t  res
);
    import pqwd_pkg::*;

    logic res_valid_reg, res_valid_next;
    res_t res_reg;
    res_t eng_res;
    logic res_free;
    logic res_load;

    assign res_free = !res_valid_reg || res_ready;

    pqwd_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_free  (res_free),
        .res_load  (res_load),
        .res       (eng_res)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= eng_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`include "process_queue_with_delete_top_assert.svh"

    `PQWD_ASSERT_NXT(a_busy_after_req, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)
    `PQWD_ASSERT_IMP(a_count_bound, clk, rst_n, res_valid, int'(res.count) <= QUEUE_DEPTH)
    `PQWD_ASSERT_IMP(a_empty_ids_zero, clk, rst_n, res_valid && res.count == '0,
                     res.head_id == '0 && res.tail_id == '0)
    `PQWD_ASSERT_IMP(a_full_no_grow, clk, rst_n, res_valid && res.status == ST_FULL,
                     int'(res.count) == QUEUE_DEPTH)

endmodule
